[rtl/acs_pkg.sv]
package acs_pkg;

    localparam int C_MEM_BYTES = 1536;
    localparam int C_ADDR_W    = 11;
    localparam int C_DATA_W    = 8;

    localparam logic [7:0] OP_LDI = 8'h50;
    localparam logic [7:0] OP_STA = 8'h51;
    localparam logic [7:0] OP_ADD = 8'h5A;
    localparam logic [7:0] OP_SUB = 8'h5B;
    localparam logic [7:0] OP_JMP = 8'h6E;
    localparam logic [7:0] OP_BNE = 8'h70;
    localparam logic [7:0] OP_HLT = 8'hFF;

    typedef enum logic [1:0] {
        CMD_WR  = 2'd0,
        CMD_RD  = 2'd1,
        CMD_EXA = 2'd2,
        CMD_EXP = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_HALT    = 3'd1,
        ST_BADOP   = 3'd2,
        ST_PASTTOP = 3'd3,
        ST_BADADDR = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        MS_CLR = 3'd0,
        MS_A   = 3'd1,
        MS_A1  = 3'd2,
        MS_A2  = 3'd3,
        MS_A3  = 3'd4,
        MS_TGT = 3'd5
    } t_msel;

    typedef enum logic [2:0] {
        CAP_NONE = 3'd0,
        CAP_OP   = 3'd1,
        CAP_B1   = 3'd2,
        CAP_B2   = 3'd3,
        CAP_B3   = 3'd4
    } t_cap;

    typedef struct packed {
        logic  clr;
        logic  load;
        logic  check;
        logic  rd;
        t_msel msel;
        t_cap  cap;
        logic  rdat;
        logic  exec;
        logic  res_load;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic start_ok;
        logic clr_last;
        logic out_free;
    } t_dp_stat;

endpackage

[rtl/acs_in_if.sv]
interface acs_in_if;
    import acs_pkg::*;

    logic                valid;
    logic                ready;
    t_cmd                command;
    logic [C_ADDR_W-1:0] address;
    logic [C_DATA_W-1:0] write_data;

    modport source(output valid, command, address, write_data, input ready);
    modport sink(input valid, command, address, write_data, output ready);
endinterface

[rtl/acs_out_if.sv]
interface acs_out_if;
    import acs_pkg::*;

    logic                valid;
    logic                ready;
    t_status             status;
    logic [C_ADDR_W-1:0] program_counter;
    logic [C_DATA_W-1:0] accumulator;
    logic [C_DATA_W-1:0] read_data;

    modport source(output valid, status, program_counter, accumulator, read_data,
                   input ready);
    modport sink(input valid, status, program_counter, accumulator, read_data,
                 output ready);
endinterface

[rtl/acs_ctrl.sv]
module acs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  acs_pkg::t_dp_stat i_stat,
    output acs_pkg::t_dp_cmd  o_cmd
);
    import acs_pkg::*;

    typedef enum logic [11:0] {
        S_CLEAR = 12'b0000_0000_0001,
        S_IDLE  = 12'b0000_0000_0010,
        S_CHECK = 12'b0000_0000_0100,
        S_RREQ  = 12'b0000_0000_1000,
        S_RDAT  = 12'b0000_0001_0000,
        S_F0    = 12'b0000_0010_0000,
        S_F1    = 12'b0000_0100_0000,
        S_F2    = 12'b0000_1000_0000,
        S_F3    = 12'b0001_0000_0000,
        S_F4    = 12'b0010_0000_0000,
        S_EXEC  = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_ready        = 1'b0;
        o_cmd          = '0;
        o_cmd.msel     = MS_A;
        o_cmd.cap      = CAP_NONE;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr  = 1'b1;
                o_cmd.msel = MS_CLR;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
                if (i_valid) n_state = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                if (!i_stat.start_ok || i_stat.cmd == CMD_WR) n_state = S_DONE;
                else if (i_stat.cmd == CMD_RD)                 n_state = S_RREQ;
                else                                           n_state = S_F0;
            end
            S_RREQ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_RDAT;
            end
            S_RDAT: begin
                o_cmd.rdat = 1'b1;
                n_state    = S_DONE;
            end
            S_F0: begin
                o_cmd.rd = 1'b1;
                n_state  = S_F1;
            end
            S_F1: begin
                o_cmd.rd   = 1'b1;
                o_cmd.msel = MS_A1;
                o_cmd.cap  = CAP_OP;
                n_state    = S_F2;
            end
            S_F2: begin
                o_cmd.rd   = 1'b1;
                o_cmd.msel = MS_A2;
                o_cmd.cap  = CAP_B1;
                n_state    = S_F3;
            end
            S_F3: begin
                o_cmd.rd   = 1'b1;
                o_cmd.msel = MS_A3;
                o_cmd.cap  = CAP_B2;
                n_state    = S_F4;
            end
            S_F4: begin
                o_cmd.cap = CAP_B3;
                n_state   = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                o_cmd.msel = MS_TGT;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

endmodule

[rtl/acs_datapath.sv]
module acs_datapath #(
    parameter int MEM_BYTES = acs_pkg::C_MEM_BYTES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  acs_pkg::t_dp_cmd                 i_cmd,
    output acs_pkg::t_dp_stat                o_stat,
    input  acs_pkg::t_cmd                    i_command,
    input  logic [acs_pkg::C_ADDR_W-1:0]     i_address,
    input  logic [acs_pkg::C_DATA_W-1:0]     i_write_data,
    output logic                             o_valid,
    input  logic                             i_ready,
    output acs_pkg::t_status                 o_status,
    output logic [acs_pkg::C_ADDR_W-1:0]     o_program_counter,
    output logic [acs_pkg::C_DATA_W-1:0]     o_accumulator,
    output logic [acs_pkg::C_DATA_W-1:0]     o_read_data
);
    import acs_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);
    localparam int XW = ((AW > 16) ? AW : 16) + 1;
    localparam logic [XW-1:0] LIM = XW'(MEM_BYTES);

    logic [C_DATA_W-1:0] mem [MEM_BYTES];

    t_cmd                r_cmd;
    logic [XW-1:0]       r_a;
    logic [C_DATA_W-1:0] r_wd;
    logic [C_DATA_W-1:0] r_mrd;
    logic [C_DATA_W-1:0] r_op, r_b1, r_b2, r_b3;
    logic [C_DATA_W-1:0] r_acc;
    logic [AW-1:0]       r_pc;
    logic [AW-1:0]       r_clr;
    t_status             r_res_st;
    logic [C_DATA_W-1:0] r_res_rd;
    logic                r_ov;
    t_status             r_o_st;
    logic [C_ADDR_W-1:0] r_o_pc;
    logic [C_DATA_W-1:0] r_o_acc;
    logic [C_DATA_W-1:0] r_o_rd;

    logic [XW-1:0]       a1, a2, a3, a4, tgt1, tgt2, m_addr, pcx;
    logic                m_inr, m_we, m_re;
    logic [C_DATA_W-1:0] m_wd;
    t_status             x_st;
    logic [C_DATA_W-1:0] x_acc;
    logic [AW-1:0]       x_pc;
    logic                x_we;

    assign a1   = r_a + XW'(1);
    assign a2   = r_a + XW'(2);
    assign a3   = r_a + XW'(3);
    assign a4   = r_a + XW'(4);
    assign tgt1 = XW'({r_b1, r_b2});
    assign tgt2 = XW'({r_b2, r_b3});

    always_comb begin
        case (i_cmd.msel)
            MS_CLR:  m_addr = XW'(r_clr);
            MS_A:    m_addr = r_a;
            MS_A1:   m_addr = a1;
            MS_A2:   m_addr = a2;
            MS_A3:   m_addr = a3;
            MS_TGT:  m_addr = tgt1;
            default: m_addr = r_a;
        endcase
    end

    assign m_inr = (m_addr < LIM);

    always_comb begin
        x_st  = ST_OK;
        x_acc = r_acc;
        x_pc  = r_pc;
        x_we  = 1'b0;
        case (r_op)
            OP_LDI: begin
                if (a2 >= LIM) begin
                    x_st = ST_PASTTOP;
                end else begin
                    x_acc = r_b1;
                    x_pc  = a2[AW-1:0];
                end
            end
            OP_STA: begin
                if (a3 >= LIM) begin
                    x_st = ST_PASTTOP;
                end else if (tgt1 >= LIM) begin
                    x_st = ST_BADADDR;
                end else begin
                    x_we = 1'b1;
                    x_pc = a3[AW-1:0];
                end
            end
            OP_ADD, OP_SUB: begin
                if (a2 >= LIM) begin
                    x_st = ST_PASTTOP;
                end else begin
                    x_acc = (r_op == OP_ADD) ? r_acc + r_b1 : r_acc - r_b1;
                    x_pc  = a2[AW-1:0];
                end
            end
            OP_JMP: begin
                if (a2 >= LIM) begin
                    x_st = ST_PASTTOP;
                end else if (tgt1 >= LIM) begin
                    x_st = ST_BADADDR;
                end else begin
                    x_pc = tgt1[AW-1:0];
                end
            end
            OP_BNE: begin
                if (a4 >= LIM) begin
                    x_st = ST_PASTTOP;
                end else if (r_b1 == r_acc) begin
                    x_pc = a4[AW-1:0];
                end else if (tgt2 >= LIM) begin
                    x_st = ST_BADADDR;
                end else begin
                    x_pc = tgt2[AW-1:0];
                end
            end
            OP_HLT:  x_st = ST_HALT;
            default: x_st = ST_BADOP;
        endcase
    end

    assign m_we = i_cmd.clr
                | (i_cmd.check && r_cmd == CMD_WR && m_inr)
                | (i_cmd.exec && x_we);
    assign m_re = i_cmd.rd && m_inr;
    assign m_wd = i_cmd.clr ? '0 : (i_cmd.check ? r_wd : r_acc);

    always_ff @(posedge i_clk) begin
        if (m_we) begin
            mem[m_addr[AW-1:0]] <= m_wd;
        end else if (m_re) begin
            r_mrd <= mem[m_addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
            r_acc <= '0;
            r_pc  <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (i_cmd.clr) r_clr <= r_clr + AW'(1);
            if (i_cmd.exec) begin
                r_acc <= x_acc;
                r_pc  <= x_pc;
            end
            if (i_cmd.res_load) r_ov <= 1'b1;
            else if (i_ready)   r_ov <= 1'b0;
        end
    end

    assign pcx = XW'(r_pc);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_command;
            r_wd  <= i_write_data;
            r_a   <= (i_command == CMD_EXP) ? XW'(r_pc) : XW'(i_address);
        end
        if (i_cmd.check) begin
            r_res_st <= m_inr ? ST_OK : ST_BADADDR;
            r_res_rd <= '0;
        end
        case (i_cmd.cap)
            CAP_OP:  r_op <= r_mrd;
            CAP_B1:  r_b1 <= r_mrd;
            CAP_B2:  r_b2 <= r_mrd;
            CAP_B3:  r_b3 <= r_mrd;
            default: ;
        endcase
        if (i_cmd.rdat) r_res_rd <= r_mrd;
        if (i_cmd.exec) r_res_st <= x_st;
        if (i_cmd.res_load) begin
            r_o_st  <= r_res_st;
            r_o_pc  <= pcx[C_ADDR_W-1:0];
            r_o_acc <= r_acc;
            r_o_rd  <= r_res_rd;
        end
    end

    assign o_stat.cmd      = r_cmd;
    assign o_stat.start_ok = (r_a < LIM);
    assign o_stat.clr_last = (r_clr == AW'(MEM_BYTES - 1));
    assign o_stat.out_free = !r_ov || i_ready;

    assign o_valid           = r_ov;
    assign o_status          = r_o_st;
    assign o_program_counter = r_o_pc;
    assign o_accumulator     = r_o_acc;
    assign o_read_data       = r_o_rd;

endmodule

[rtl/accumulator_cpu_step_core.sv]
// Sequencer states per item: byte write or bad address CHECK then DONE;
// byte read CHECK, RREQ, RDAT, DONE; instruction CHECK, F0 to F4, EXEC, DONE.
// One item in flight at a time; DONE stalls while a result is still unread.
// Opcode and three operand fetches step through the single memory port.
// Reset: i_rst_n synchronous, active low; clears acc and pc, then a clearing
// pass writes zero to all MEM_BYTES memory bytes (ready low).
module accumulator_cpu_step_core #(
    parameter int MEM_BYTES = acs_pkg::C_MEM_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    acs_in_if.sink     i_in,
    acs_out_if.source  o_out
);
    import acs_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    acs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    acs_datapath #(
        .MEM_BYTES (MEM_BYTES)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (dp_cmd),
        .o_stat            (dp_stat),
        .i_command         (i_in.command),
        .i_address         (i_in.address),
        .i_write_data      (i_in.write_data),
        .o_valid           (o_out.valid),
        .i_ready           (o_out.ready),
        .o_status          (o_out.status),
        .o_program_counter (o_out.program_counter),
        .o_accumulator     (o_out.accumulator),
        .o_read_data       (o_out.read_data)
    );

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !dp_cmd.clr)
        else $error("input ready during clearing pass");

    a_accept_then_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> dp_cmd.check)
        else $error("accepted transaction not checked next cycle");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.res_load |-> (!o_out.valid || o_out.ready))
        else $error("pending result overwritten");

    a_one_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({dp_cmd.clr, dp_cmd.load, dp_cmd.check, dp_cmd.exec, dp_cmd.res_load}))
        else $error("conflicting datapath commands");

endmodule

[sim/tb.sv]
module tb;
    import acs_pkg::*;

    localparam int IDLE_LIMIT   = 20000;
    localparam int RANDOM_ITEMS = 1050;
    localparam int QUEUE_DEPTH  = 8;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [7:0] OPCODE_SET [7] = '{OP_LDI, OP_STA, OP_ADD, OP_SUB,
                                               OP_JMP, OP_BNE, OP_HLT};

    typedef struct {
        t_cmd                cmd;
        logic [C_ADDR_W-1:0] addr;
        logic [C_DATA_W-1:0] data;
    } t_cmd_item;

    typedef struct {
        t_status             status;
        logic [C_ADDR_W-1:0] pc;
        logic [C_DATA_W-1:0] acc;
        logic [C_DATA_W-1:0] rdata;
    } t_step_result;

    logic i_clk;
    logic i_rst_n;

    acs_in_if  in_if();
    acs_out_if out_if();

    accumulator_cpu_step_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    logic [C_DATA_W-1:0] shadow_mem [C_MEM_BYTES] = '{default: '0};
    logic [C_DATA_W-1:0] shadow_acc = '0;
    logic [C_ADDR_W-1:0] shadow_pc  = '0;

    t_cmd_item    pending_cmds[$];
    t_step_result expected_results[$];
    t_cmd_item    next_item;
    t_step_result want;

    int cmds_queued    = 0;
    int cmds_accepted  = 0;
    int results_seen   = 0;
    int err_cnt        = 0;
    int idle_cycles    = 0;
    int burst_left     = 0;
    int gap_left       = 0;
    int hold_left      = 0;
    int mode_left      = 0;
    int sink_mode      = 0;
    bit long_hold_done = 1'b0;

    // one instruction on the shadow machine; failures leave state untouched
    function automatic t_status exec_instr(int unsigned a);
        logic [7:0]  op;
        int unsigned tgt;
        if (a >= C_MEM_BYTES) return ST_BADADDR;
        op = shadow_mem[a];
        case (op)
            OP_LDI: begin
                if (a + 2 >= C_MEM_BYTES) return ST_PASTTOP;
                shadow_acc = shadow_mem[a+1];
                shadow_pc  = C_ADDR_W'(a + 2);
            end
            OP_STA: begin
                if (a + 3 >= C_MEM_BYTES) return ST_PASTTOP;
                tgt = {shadow_mem[a+1], shadow_mem[a+2]};
                if (tgt >= C_MEM_BYTES) return ST_BADADDR;
                shadow_mem[tgt] = shadow_acc;
                shadow_pc       = C_ADDR_W'(a + 3);
            end
            OP_ADD, OP_SUB: begin
                if (a + 2 >= C_MEM_BYTES) return ST_PASTTOP;
                if (op == OP_ADD) shadow_acc = shadow_acc + shadow_mem[a+1];
                else shadow_acc = shadow_acc - shadow_mem[a+1];
                shadow_pc = C_ADDR_W'(a + 2);
            end
            OP_JMP: begin
                if (a + 2 >= C_MEM_BYTES) return ST_PASTTOP;
                tgt = {shadow_mem[a+1], shadow_mem[a+2]};
                if (tgt >= C_MEM_BYTES) return ST_BADADDR;
                shadow_pc = C_ADDR_W'(tgt);
            end
            OP_BNE: begin
                if (a + 4 >= C_MEM_BYTES) return ST_PASTTOP;
                if (shadow_mem[a+1] == shadow_acc) begin
                    shadow_pc = C_ADDR_W'(a + 4);
                end else begin
                    tgt = {shadow_mem[a+2], shadow_mem[a+3]};
                    if (tgt >= C_MEM_BYTES) return ST_BADADDR;
                    shadow_pc = C_ADDR_W'(tgt);
                end
            end
            OP_HLT: return ST_HALT;
            default: return ST_BADOP;
        endcase
        return ST_OK;
    endfunction

    function automatic t_step_result cpu_step(t_cmd cmd, logic [C_ADDR_W-1:0] addr,
                                              logic [C_DATA_W-1:0] wdata);
        t_step_result r;
        r.status = ST_OK;
        r.rdata  = '0;
        case (cmd)
            CMD_WR: begin
                if (addr < C_MEM_BYTES) shadow_mem[addr] = wdata;
                else r.status = ST_BADADDR;
            end
            CMD_RD: begin
                if (addr < C_MEM_BYTES) r.rdata = shadow_mem[addr];
                else r.status = ST_BADADDR;
            end
            CMD_EXA: r.status = exec_instr(addr);
            default: r.status = exec_instr(shadow_pc);
        endcase
        r.pc  = shadow_pc;
        r.acc = shadow_acc;
        return r;
    endfunction

    function automatic int pick_target();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return $urandom_range(0, 63);
        if (r < 8) return $urandom_range(1472, C_MEM_BYTES - 1);
        return $urandom_range(C_MEM_BYTES, 65535);
    endfunction

    task automatic queue_cmd(t_cmd c, int a, int d);
        t_cmd_item it;
        it.cmd  = c;
        it.addr = C_ADDR_W'(a);
        it.data = C_DATA_W'(d);
        while (pending_cmds.size() >= QUEUE_DEPTH) @(posedge i_clk);
        pending_cmds.push_back(it);
        cmds_queued++;
    endtask

    task automatic drain_inputs();
        while (cmds_accepted != cmds_queued) @(posedge i_clk);
    endtask

    // usually write one instruction with random operands, run it, then step zero to three times
    task automatic emit_sequence();
        int         base;
        int         roll;
        int         len;
        int         tgt;
        logic [7:0] bytes [4];
        roll = $urandom_range(0, 99);
        if (roll < 75) base = $urandom_range(0, 47);
        else if (roll < 95) base = $urandom_range(1520, C_MEM_BYTES - 1);
        else base = $urandom_range(C_MEM_BYTES, 2047);
        roll = $urandom_range(0, 7);
        bytes[0] = (roll < 7) ? OPCODE_SET[roll] : 8'($urandom_range(0, 255));
        for (int i = 1; i < 4; i++) bytes[i] = 8'($urandom_range(0, 255));
        case (bytes[0])
            OP_STA, OP_JMP: begin
                tgt      = pick_target();
                bytes[1] = tgt[15:8];
                bytes[2] = tgt[7:0];
                len      = 3;
            end
            OP_BNE: begin
                drain_inputs();
                if ($urandom_range(0, 1) == 1) bytes[1] = shadow_acc;
                tgt      = pick_target();
                bytes[2] = tgt[15:8];
                bytes[3] = tgt[7:0];
                len      = 4;
            end
            OP_LDI, OP_ADD, OP_SUB: len = 2;
            default: len = 1;
        endcase
        if ($urandom_range(0, 9) != 0) begin
            for (int i = 0; i < len; i++) queue_cmd(CMD_WR, (base + i) % 2048, bytes[i]);
        end
        queue_cmd(CMD_EXA, base, $urandom_range(0, 255));
        repeat ($urandom_range(0, 3)) begin
            queue_cmd(CMD_EXP, $urandom_range(0, 2047), $urandom_range(0, 255));
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        int  directed_n;
        bit  paused_once;
        paused_once = 1'b0;

        queue_cmd(CMD_WR, 0, OP_LDI);
        queue_cmd(CMD_WR, 1, 8'hFF);
        queue_cmd(CMD_EXA, 0, 0);
        queue_cmd(CMD_WR, 2, OP_ADD);
        queue_cmd(CMD_WR, 3, 1);
        queue_cmd(CMD_EXP, 0, 0);             // add wraps to zero
        queue_cmd(CMD_WR, 4, OP_SUB);
        queue_cmd(CMD_WR, 5, 1);
        queue_cmd(CMD_EXP, 0, 0);             // subtract wraps to 0xFF
        queue_cmd(CMD_WR, 6, OP_STA);
        queue_cmd(CMD_WR, 7, 8'h05);
        queue_cmd(CMD_WR, 8, 8'hFF);
        queue_cmd(CMD_EXP, 0, 0);             // store to last byte
        queue_cmd(CMD_RD, C_MEM_BYTES - 1, 0);
        queue_cmd(CMD_WR, 9, OP_BNE);
        queue_cmd(CMD_EXP, 0, 0);             // not equal, branch to 0
        queue_cmd(CMD_EXA, 2, 0);
        queue_cmd(CMD_EXA, 9, 0);             // equal, fall through
        queue_cmd(CMD_WR, 13, OP_JMP);
        queue_cmd(CMD_WR, 14, 8'h06);
        queue_cmd(CMD_EXP, 0, 0);             // jump target out of range
        queue_cmd(CMD_EXA, C_MEM_BYTES - 1, 0); // halt
        queue_cmd(CMD_WR, C_MEM_BYTES - 2, OP_LDI);
        queue_cmd(CMD_EXA, C_MEM_BYTES - 2, 0); // operand past top
        queue_cmd(CMD_EXA, 15, 0);            // unknown opcode
        queue_cmd(CMD_WR, 2047, 0);
        queue_cmd(CMD_RD, C_MEM_BYTES, 8'hFF);
        queue_cmd(CMD_EXA, 2047, 0);
        queue_cmd(CMD_RD, 0, 0);
        directed_n = cmds_queued;

        while (cmds_queued < directed_n + RANDOM_ITEMS) begin
            if (!paused_once && cmds_queued >= directed_n + 600) begin
                drain_inputs();
                while (expected_results.size() != 0) @(posedge i_clk);
                paused_once = 1'b1;
            end
            if ($urandom_range(0, 99) < 15) begin
                queue_cmd(t_cmd'($urandom_range(0, 3)),
                          ($urandom_range(0, 3) == 0) ? $urandom_range(C_MEM_BYTES, 2047)
                                                      : $urandom_range(0, C_MEM_BYTES - 1),
                          $urandom_range(0, 255));
            end else begin
                emit_sequence();
            end
        end

        drain_inputs();
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("accumulator_cpu_step_core verification clean");
        end else begin
            $display("accumulator_cpu_step_core verification failed");
        end
        $finish;
    end

    // driver: bursts of transactions separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid      <= 1'b0;
            in_if.command    <= CMD_WR;
            in_if.address    <= '0;
            in_if.write_data <= '0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                expected_results.push_back(cpu_step(in_if.command, in_if.address,
                                                    in_if.write_data));
                cmds_accepted++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_if.valid <= 1'b0;
                end else if (pending_cmds.size() != 0) begin
                    next_item = pending_cmds.pop_front();
                    in_if.command    <= next_item.cmd;
                    in_if.address    <= next_item.addr;
                    in_if.write_data <= next_item.data;
                    in_if.valid      <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                                 : $urandom_range(0, 12);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // result sink: stall mode changes at random, one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (!long_hold_done && results_seen >= 400) begin
                long_hold_done = 1'b1;
                hold_left      = 400;
            end
            if (mode_left == 0) begin
                sink_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 80);
            end else begin
                mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                case (sink_mode)
                    0: out_if.ready <= 1'b1;
                    1: out_if.ready <= ~out_if.ready;
                    2: out_if.ready <= ($urandom_range(0, 3) != 0);
                    default: out_if.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10) begin
                    $display("unexpected transaction: st %0d pc %0d acc %02h rd %02h",
                             out_if.status, out_if.program_counter, out_if.accumulator,
                             out_if.read_data);
                end
            end else begin
                want = expected_results.pop_front();
                if (out_if.status !== want.status || out_if.program_counter !== want.pc ||
                    out_if.accumulator !== want.acc || out_if.read_data !== want.rdata) begin
                    err_cnt++;
                    if (err_cnt <= 10) begin
                        $display("mismatch #%0d: exp st %0d pc %0d acc %02h rd %02h,",
                                 results_seen, want.status, want.pc, want.acc, want.rdata,
                                 " got st %0d pc %0d acc %02h rd %02h",
                                 out_if.status, out_if.program_counter, out_if.accumulator,
                                 out_if.read_data);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("accumulator_cpu_step_core verification failed");
            $finish;
        end
    end

endmodule
